@@ rtl/pss_pkg.sv @@
// ----------------------------------------------------------------------------
// pss_pkg: shared types and constants of the priority step scheduler
// Holds the store geometry, event codes, request codes and the packed
// transaction and slot types used by all scheduler modules.
// ----------------------------------------------------------------------------
package pss_pkg;

    // Store geometry and value width.
    localparam int QUEUE_DEPTH = 8;
    localparam int VALUE_BITS  = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int PROG_W      = 5;
    localparam int SQ_W        = 2 * VALUE_BITS;

    // Request codes.
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    // Event codes reported with every result.
    localparam logic [2:0] EV_IDLE     = 3'd0;
    localparam logic [2:0] EV_STEP     = 3'd1;
    localparam logic [2:0] EV_COMPLETE = 3'd2;
    localparam logic [2:0] EV_ACCEPT   = 3'd3;
    localparam logic [2:0] EV_DROP     = 3'd4;

    // Input transaction payload.
    typedef struct packed {
        logic        req_type;
        logic [15:0] task_value;
        logic [3:0]  task_priority;
        logic [3:0]  task_steps;
    } t_in_item;

    // Output transaction payload.
    typedef struct packed {
        logic [2:0]  event_kind;
        logic [15:0] out_value;
        logic [3:0]  out_priority;
        logic [4:0]  step_number;
        logic [3:0]  step_total;
        logic [31:0] square_result;
    } t_out_item;

    // One stored task.
    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [3:0]            prio;
        logic [3:0]            steps;
        logic [PROG_W-1:0]     progress;
    } t_slot;

endpackage

@@ rtl/pss_slot_ram.sv @@
// ----------------------------------------------------------------------------
// pss_slot_ram: task slot storage
// One write port and one read port with registered read data. Entries are
// undefined until written; data read past the fill count goes unused.
// ----------------------------------------------------------------------------
module pss_slot_ram
    import pss_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  t_slot            i_wdata,
    input  logic [IDX_W-1:0] i_raddr,
    output t_slot            o_rdata
);

    t_slot r_mem [QUEUE_DEPTH];
    t_slot r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/pss_square.sv @@
// ----------------------------------------------------------------------------
// pss_square: registered squaring unit
// Squares a task value into a register and keeps the low 32 bits of the
// exact product for the completion report.
// ----------------------------------------------------------------------------
module pss_square
    import pss_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic [31:0]           o_square
);

    logic [SQ_W-1:0] r_prod;

    // The product is captured when the sequencer starts a completion.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= SQ_W'(i_value) * SQ_W'(i_value);
        end
    end

    assign o_square = 32'(r_prod);

endmodule

@@ rtl/priority_step_scheduler.sv @@
// ----------------------------------------------------------------------------
// priority_step_scheduler: single-thread priority task scheduler
// An insert adds a task to a packed slot store unless it is full; a tick serves the oldest
// task of highest priority, reporting a step or its completion.
// ----------------------------------------------------------------------------
// An insert and a tick on an empty store are answered from the idle
// state. A tick on a store holding N tasks scans the slot memory one
// entry per cycle through a single priority comparator, then decides
// between a step and a completion. A completion additionally compacts
// the store one entry per cycle behind the removed slot. The single
// read port of the slot memory sets this pace. One transaction is
// worked on at a time; a finished result sits in the output register
// and the next transaction is taken as soon as it can be placed.
// Slot contents need no clearing after reset.
// ----------------------------------------------------------------------------
module priority_step_scheduler
    import pss_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_MOVE   = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]       r_state,     n_state;
    logic [IDX_W-1:0] r_idx,       n_idx;
    logic [IDX_W-1:0] r_best_idx,  n_best_idx;
    t_slot            r_best,      n_best;
    logic [CNT_W-1:0] r_count,     n_count;
    logic [2:0]       r_kind,      n_kind;
    t_out_item        r_out,       n_out;
    logic             r_out_valid, n_out_valid;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    t_slot            mem_wdata;
    logic [IDX_W-1:0] mem_raddr;
    t_slot            mem_rdata;
    logic             sq_en;
    logic [31:0]      sq_result;
    logic             out_free;
    logic             in_acc;
    logic             idx_last;

    // Slot store and squaring unit.
    pss_slot_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    pss_square u_square (
        .i_clk    (i_clk),
        .i_en     (sq_en),
        .i_value  (r_best.value),
        .o_square (sq_result)
    );

    // Handshake helpers.
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign in_acc     = i_in_valid && o_in_ready;
    assign idx_last   = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);

    // Sequencer next-state logic.
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_best_idx  = r_best_idx;
        n_best      = r_best;
        n_count     = r_count;
        n_kind      = r_kind;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        mem_we      = 1'b0;
        mem_waddr   = r_idx;
        mem_wdata   = mem_rdata;
        mem_raddr   = '0;
        sq_en       = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                mem_raddr = '0;
                if (in_acc) begin
                    n_out       = '0;
                    n_out_valid = 1'b1;
                    if (i_in_data.req_type == REQ_INSERT) begin
                        if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                            n_out.event_kind = EV_DROP;
                        end else begin
                            mem_we             = 1'b1;
                            mem_waddr          = r_count[IDX_W-1:0];
                            mem_wdata.value    = VALUE_BITS'(i_in_data.task_value);
                            mem_wdata.prio     = i_in_data.task_priority;
                            mem_wdata.steps    = i_in_data.task_steps;
                            mem_wdata.progress = PROG_W'(1);
                            n_count            = r_count + CNT_W'(1);
                            n_out.event_kind   = EV_ACCEPT;
                        end
                    end else if (r_count == '0) begin
                        n_out.event_kind = EV_IDLE;
                    end else begin
                        // Tick on a non-empty store: start the scan.
                        n_out_valid = r_out_valid && !i_out_ready;
                        n_out       = r_out;
                        n_idx       = '0;
                        n_state     = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                // One slot per cycle through the comparator; ties keep the older.
                mem_raddr = r_idx + IDX_W'(1);
                if ((r_idx == '0) || (mem_rdata.prio > r_best.prio)) begin
                    n_best     = mem_rdata;
                    n_best_idx = r_idx;
                end
                if (idx_last) begin
                    n_state = S_DECIDE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end

            S_DECIDE: begin
                if ({1'b0, r_best.steps} >= r_best.progress) begin
                    // Step executed: advance the progress in place.
                    mem_we             = 1'b1;
                    mem_waddr          = r_best_idx;
                    mem_wdata          = r_best;
                    mem_wdata.progress = r_best.progress + PROG_W'(1);
                    n_kind             = EV_STEP;
                    n_state            = S_DONE;
                end else begin
                    // Completion: square the value and close the gap.
                    n_kind    = EV_COMPLETE;
                    sq_en     = 1'b1;
                    n_idx     = r_best_idx;
                    mem_raddr = r_best_idx + IDX_W'(1);
                    n_state   = S_MOVE;
                end
            end

            S_MOVE: begin
                // Shift younger entries down by one slot.
                mem_raddr = r_idx + IDX_W'(2);
                if (!idx_last) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_idx;
                    mem_wdata = mem_rdata;
                    n_idx     = r_idx + IDX_W'(1);
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                if (out_free) begin
                    n_out.event_kind    = r_kind;
                    n_out.out_value     = 16'(r_best.value);
                    n_out.out_priority  = r_best.prio;
                    n_out.step_number   = r_best.progress;
                    n_out.step_total    = r_best.steps;
                    n_out.square_result = (r_kind == EV_COMPLETE) ? sq_result : 32'd0;
                    n_out_valid         = 1'b1;
                    n_state             = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_best_idx <= n_best_idx;
        r_best     <= n_best;
        r_kind     <= n_kind;
        r_out      <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The fill count never exceeds the store depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("slot count exceeds store depth");

    // An accepted insert into a store with room grows the count by one.
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in_data.req_type == REQ_INSERT) &&
         (r_count != CNT_W'(QUEUE_DEPTH)))
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow the slot count");

    // A scan only runs over a non-empty store.
    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_count != '0))
        else $error("scan started on an empty store");

    // A completion removes exactly one task.
    a_complete_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_MOVE) && idx_last) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("completion did not shrink the slot count");

endmodule
